>>> hdl/gprc_pkg.sv
// Shared types, constants and helpers of the gamepad report conditioner.
// Depends on nothing; used by every module in hdl.
package gprc_pkg;

    localparam logic [14:0] STICK_FULL  = 15'd32767;
    localparam logic [14:0] LEFT_DZ_RST = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

    localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DZ = 2'd1;

    typedef struct packed {
        logic [15:0]        buttons;
        logic [15:0]        changed;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [15:0]        ltrig;
        logic [15:0]        rtrig;
    } report_t;

    // Applies the sign and clamps to the full or to the third-scale range.
    function automatic logic [15:0] axis_sat(input logic [15:0] q, input logic neg,
                                             input logic third);
        logic [15:0] res;
        if (!third)
        begin
            if (neg)
                res = 16'(-q);
            else if (q > 16'd32767)
                res = 16'd32767;
            else
                res = q;
        end
        else
        begin
            if (neg)
                res = (q > 16'd16384) ? 16'hC000 : 16'(-q);
            else if (q > 16'd16383)
                res = 16'd16383;
            else
                res = q;
        end
        return res;
    endfunction

endpackage

>>> hdl/gprc_front.sv
// Front end: accepts reports, drops stale or disconnected ones, tracks state.
// Depends on gprc_pkg.
module gprc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    connected,
    input  logic [31:0]             packet_number,
    input  logic [15:0]             button_bits,
    input  logic signed [15:0]      left_stick_x,
    input  logic signed [15:0]      left_stick_y,
    input  logic signed [15:0]      right_stick_x,
    input  logic signed [15:0]      right_stick_y,
    input  logic [7:0]              left_trigger_raw,
    input  logic [7:0]              right_trigger_raw,
    input  logic                    queue_full,
    output logic                    push,
    output gprc_pkg::report_t       push_data
);

    logic [31:0] last_packet_reg, last_packet_next;
    logic [15:0] last_buttons_reg, last_buttons_next;

    assign in_ready = !queue_full;
    assign push = in_valid && in_ready && connected && (packet_number != last_packet_reg);

    always_comb
    begin
        push_data.buttons = button_bits;
        push_data.changed = button_bits ^ last_buttons_reg;
        push_data.lx      = left_stick_x;
        push_data.ly      = left_stick_y;
        push_data.rx      = right_stick_x;
        push_data.ry      = right_stick_y;
        // Multiplying a byte by 257 just repeats it in both halves.
        push_data.ltrig   = {left_trigger_raw, left_trigger_raw};
        push_data.rtrig   = {right_trigger_raw, right_trigger_raw};
        last_packet_next  = push ? packet_number : last_packet_reg;
        last_buttons_next = push ? button_bits : last_buttons_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_packet_reg  <= '0;
            last_buttons_reg <= '0;
        end
        else
        begin
            last_packet_reg  <= last_packet_next;
            last_buttons_reg <= last_buttons_next;
        end
    end

endmodule

>>> hdl/gprc_queue.sv
// Small register queue that decouples the front end from the stick engine.
// Depends on gprc_pkg.
module gprc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gprc_pkg::report_t       push_data,
    input  logic                    pop,
    output gprc_pkg::report_t       pop_data,
    output logic                    full,
    output logic                    empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gprc_pkg::report_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

>>> hdl/gprc_back.sv
// Stick engine: sequenced square root per stick and restoring divider per axis,
// plus the output register. Depends on gprc_pkg.
module gprc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [14:0]             left_dz,
    input  logic [14:0]             right_dz,
    input  logic                    queue_empty,
    input  gprc_pkg::report_t       pop_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             button_state,
    output logic [15:0]             button_changed,
    output logic signed [15:0]      left_axis_x,
    output logic signed [15:0]      left_axis_y,
    output logic signed [14:0]      right_axis_x,
    output logic signed [14:0]      right_axis_y,
    output logic [15:0]             left_trigger_level,
    output logic [15:0]             right_trigger_level
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SQX  = 10'b0000000010,
        ST_SQY  = 10'b0000000100,
        ST_ROOT = 10'b0000001000,
        ST_CHK  = 10'b0000010000,
        ST_DEN  = 10'b0000100000,
        ST_DEN3 = 10'b0001000000,
        ST_NUM  = 10'b0010000000,
        ST_DIV  = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    gprc_pkg::report_t  item_reg;
    logic               stick_reg;
    logic               axis_reg;
    logic [3:0]         cnt_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        val_reg;
    logic [19:0]        rem_reg;
    logic [15:0]        root_reg;
    logic [14:0]        m_reg;
    logic [32:0]        den_reg;
    logic [45:0]        num_reg;
    logic [47:0]        dsh_reg;
    logic [15:0]        q_reg;
    logic [15:0]        res_reg [4];
    logic               out_valid_reg;

    logic signed [15:0] sx, sy, sv;
    logic [15:0]        ax, ay, av;
    logic [14:0]        dz;
    logic [19:0]        rem_sh, trial;
    logic               rem_ge;
    logic               q_bit;
    logic [15:0]        q_fin;
    logic               load_out;

    always_comb
    begin
        sx    = stick_reg ? item_reg.rx : item_reg.lx;
        sy    = stick_reg ? item_reg.ry : item_reg.ly;
        ax    = sx[15] ? 16'(-sx) : 16'(sx);
        ay    = sy[15] ? 16'(-sy) : 16'(sy);
        sv    = axis_reg ? sy : sx;
        av    = axis_reg ? ay : ax;
        dz    = stick_reg ? right_dz : left_dz;
        rem_sh = {rem_reg[17:0], val_reg[31:30]};
        trial  = {2'b00, root_reg, 2'b01};
        rem_ge = (rem_sh >= trial);
        q_bit  = ({2'b00, num_reg} >= dsh_reg);
        q_fin  = {q_reg[14:0], q_bit};
    end

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!queue_empty) state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == 4'd15) state_next = ST_CHK;
            ST_CHK:
            begin
                if (dz == gprc_pkg::STICK_FULL || root_reg <= {1'b0, dz})
                    state_next = stick_reg ? ST_OUT : ST_SQX;
                else
                    state_next = ST_DEN;
            end
            ST_DEN:  state_next = ST_DEN3;
            ST_DEN3: state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 4'd15)
                begin
                    if (!axis_reg)
                        state_next = ST_NUM;
                    else
                        state_next = stick_reg ? ST_OUT : ST_SQX;
                end
            end
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg  <= pop_data;
                stick_reg <= 1'b0;
            end
            ST_SQX:  acc_reg <= ax * ax;
            ST_SQY:
            begin
                val_reg  <= acc_reg + ay * ay;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_ROOT:
            begin
                // One result bit per cycle, two radicand bits consumed.
                val_reg  <= {val_reg[29:0], 2'b00};
                rem_reg  <= rem_ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[14:0], rem_ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_CHK:
            begin
                axis_reg <= 1'b0;
                m_reg    <= (root_reg > {1'b0, gprc_pkg::STICK_FULL})
                            ? gprc_pkg::STICK_FULL - dz : root_reg[14:0] - dz;
                if (dz == gprc_pkg::STICK_FULL || root_reg <= {1'b0, dz})
                begin
                    res_reg[{stick_reg, 1'b0}] <= '0;
                    res_reg[{stick_reg, 1'b1}] <= '0;
                    stick_reg <= 1'b1;
                end
            end
            ST_DEN:  den_reg <= 33'(root_reg * (gprc_pkg::STICK_FULL - dz));
            ST_DEN3: if (stick_reg) den_reg <= den_reg + {den_reg[31:0], 1'b0};
            ST_NUM:
            begin
                num_reg <= {31'(av * m_reg), 15'b0};
                dsh_reg <= {den_reg, 15'b0};
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (q_bit)
                    num_reg <= num_reg - dsh_reg[45:0];
                dsh_reg <= {1'b0, dsh_reg[47:1]};
                q_reg   <= q_fin;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    res_reg[{stick_reg, axis_reg}] <= gprc_pkg::axis_sat(q_fin, sv[15],
                                                                         stick_reg);
                    axis_reg <= 1'b1;
                    if (axis_reg)
                        stick_reg <= 1'b1;
                end
            end
            default: ;
        endcase
        if (load_out)
        begin
            button_state        <= item_reg.buttons;
            button_changed      <= item_reg.changed;
            left_axis_x         <= res_reg[0];
            left_axis_y         <= res_reg[1];
            right_axis_x        <= res_reg[2][14:0];
            right_axis_y        <= res_reg[3][14:0];
            left_trigger_level  <= item_reg.ltrig;
            right_trigger_level <= item_reg.rtrig;
        end
    end

    assign out_valid = out_valid_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_SQX))
        else $error("engine took an item outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before it was taken");
    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> ($past(state_reg) == ST_ROOT))
        else $error("magnitude check without finished root");

endmodule

>>> hdl/gamepad_report_conditioner.sv
// Each stick runs a 16-step square root and a magnitude check, then two
// 16-step divisions when it lies outside its dead zone. The engine passes
// through its idle and output states per report and takes a new report
// only in idle, so reports wait in the queue; output stalls hold it in the
// output state. Dropped reports never enter the queue. Reset clears
// packet/button history and loads the dead zones with 7849 and 8689; no
// clearing pass is needed. Top level of the gamepad report conditioner;
// depends on gprc_pkg, gprc_front, gprc_queue and gprc_back.
module gamepad_report_conditioner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               connected,
    input  logic [31:0]        packet_number,
    input  logic [15:0]        button_bits,
    input  logic signed [15:0] left_stick_x,
    input  logic signed [15:0] left_stick_y,
    input  logic signed [15:0] right_stick_x,
    input  logic signed [15:0] right_stick_y,
    input  logic [7:0]         left_trigger_raw,
    input  logic [7:0]         right_trigger_raw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        button_state,
    output logic [15:0]        button_changed,
    output logic signed [15:0] left_axis_x,
    output logic signed [15:0] left_axis_y,
    output logic signed [14:0] right_axis_x,
    output logic signed [14:0] right_axis_y,
    output logic [15:0]        left_trigger_level,
    output logic [15:0]        right_trigger_level
);

    logic [14:0] left_dz_reg, left_dz_next;
    logic [14:0] right_dz_reg, right_dz_next;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    gprc_pkg::report_t    push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        left_dz_next  = left_dz_reg;
        right_dz_next = right_dz_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                gprc_pkg::REG_LEFT_DZ:  left_dz_next  = cfg_data;
                gprc_pkg::REG_RIGHT_DZ: right_dz_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= gprc_pkg::LEFT_DZ_RST;
            right_dz_reg <= gprc_pkg::RIGHT_DZ_RST;
        end
        else
        begin
            left_dz_reg  <= left_dz_next;
            right_dz_reg <= right_dz_next;
        end
    end

    gprc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .connected         (connected),
        .packet_number     (packet_number),
        .button_bits       (button_bits),
        .left_stick_x      (left_stick_x),
        .left_stick_y      (left_stick_y),
        .right_stick_x     (right_stick_x),
        .right_stick_y     (right_stick_y),
        .left_trigger_raw  (left_trigger_raw),
        .right_trigger_raw (right_trigger_raw),
        .queue_full        (q_full),
        .push              (q_push),
        .push_data         (push_data)
    );

    gprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gprc_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .left_dz             (left_dz_reg),
        .right_dz            (right_dz_reg),
        .queue_empty         (q_empty),
        .pop_data            (pop_data),
        .pop                 (q_pop),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .button_state        (button_state),
        .button_changed      (button_changed),
        .left_axis_x         (left_axis_x),
        .left_axis_y         (left_axis_y),
        .right_axis_x        (right_axis_x),
        .right_axis_y        (right_axis_y),
        .left_trigger_level  (left_trigger_level),
        .right_trigger_level (right_trigger_level)
    );

endmodule

>>> tb/sv/report_checker.sv
// Checker for the gamepad report conditioner: watches the config, report and
// result channels, predicts each result and compares it. Depends on gprc_pkg.
module report_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               connected,
    input  logic [31:0]        packet_number,
    input  logic [15:0]        button_bits,
    input  logic signed [15:0] left_stick_x,
    input  logic signed [15:0] left_stick_y,
    input  logic signed [15:0] right_stick_x,
    input  logic signed [15:0] right_stick_y,
    input  logic [7:0]         left_trigger_raw,
    input  logic [7:0]         right_trigger_raw,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        button_state,
    input  logic [15:0]        button_changed,
    input  logic signed [15:0] left_axis_x,
    input  logic signed [15:0] left_axis_y,
    input  logic signed [14:0] right_axis_x,
    input  logic signed [14:0] right_axis_y,
    input  logic [15:0]        left_trigger_level,
    input  logic [15:0]        right_trigger_level,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] buttons;
        logic [15:0] changed;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [14:0] rx;
        logic [14:0] ry;
        logic [15:0] ltrig;
        logic [15:0] rtrig;
    } conditioned_t;

    conditioned_t expected_reports[$];
    logic [14:0]  left_dz;
    logic [14:0]  right_dz;
    logic [31:0]  prev_packet;
    logic [15:0]  prev_buttons;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Radial dead zone on one stick; div is 1 for full scale, 3 for a third.
    function automatic void shape_stick(input logic signed [15:0] sx,
                                        input logic signed [15:0] sy,
                                        input logic [14:0] dz, input int div,
                                        input longint lo, input longint hi,
                                        output longint ox, output longint oy);
        longint x;
        longint y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned mag;
        longint unsigned m;
        longint unsigned den;
        x = sx;
        y = sy;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        mag = floor_sqrt(ax * ax + ay * ay);
        ox = 0;
        oy = 0;
        if (dz >= 15'd32767 || mag <= dz)
            return;
        m = ((mag > 32767) ? 32767 : mag) - dz;
        den = mag * (32767 - dz) * div;
        ox = longint'((ax * m * 32768) / den);
        oy = longint'((ay * m * 32768) / den);
        if (x < 0) ox = -ox;
        if (y < 0) oy = -oy;
        if (ox > hi) ox = hi;
        if (ox < lo) ox = lo;
        if (oy > hi) oy = hi;
        if (oy < lo) oy = lo;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        conditioned_t c;
        longint ox;
        longint oy;
        if (!rst_n)
        begin
            left_dz      = gprc_pkg::LEFT_DZ_RST;
            right_dz     = gprc_pkg::RIGHT_DZ_RST;
            prev_packet  = '0;
            prev_buttons = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gprc_pkg::REG_LEFT_DZ)
                    left_dz = cfg_data;
                else if (cfg_index == gprc_pkg::REG_RIGHT_DZ)
                    right_dz = cfg_data;
            end
            if (in_valid && in_ready && connected && packet_number != prev_packet)
            begin
                c.buttons = button_bits;
                c.changed = button_bits ^ prev_buttons;
                shape_stick(left_stick_x, left_stick_y, left_dz, 1, -32768, 32767, ox, oy);
                c.lx = ox[15:0];
                c.ly = oy[15:0];
                shape_stick(right_stick_x, right_stick_y, right_dz, 3, -16384, 16383,
                            ox, oy);
                c.rx = ox[14:0];
                c.ry = oy[14:0];
                c.ltrig = 16'(left_trigger_raw * 257);
                c.rtrig = 16'(right_trigger_raw * 257);
                expected_reports.insert(expected_reports.size(), c);
                prev_packet  = packet_number;
                prev_buttons = button_bits;
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected result beat", button_state, 16'h0000);
                else
                begin
                    c = expected_reports.pop_front();
                    if (button_state !== c.buttons)
                        report_mismatch("button_state", button_state, c.buttons);
                    if (button_changed !== c.changed)
                        report_mismatch("button_changed", button_changed, c.changed);
                    if (left_axis_x !== c.lx)
                        report_mismatch("left_axis_x", left_axis_x, c.lx);
                    if (left_axis_y !== c.ly)
                        report_mismatch("left_axis_y", left_axis_y, c.ly);
                    if (right_axis_x !== c.rx)
                        report_mismatch("right_axis_x", {1'b0, right_axis_x}, {1'b0, c.rx});
                    if (right_axis_y !== c.ry)
                        report_mismatch("right_axis_y", {1'b0, right_axis_y}, {1'b0, c.ry});
                    if (left_trigger_level !== c.ltrig)
                        report_mismatch("left_trigger_level", left_trigger_level, c.ltrig);
                    if (right_trigger_level !== c.rtrig)
                        report_mismatch("right_trigger_level", right_trigger_level,
                                        c.rtrig);
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the gamepad report conditioner testbench: clock, reset, stimulus and
// verdict. Depends on gprc_pkg, report_checker and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE       = 150;

    // Indexes with no register behind them.
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               connected;
    logic [31:0]        packet_number;
    logic [15:0]        button_bits;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
    logic [7:0]         left_trigger_raw;
    logic [7:0]         right_trigger_raw;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        button_state;
    logic [15:0]        button_changed;
    logic signed [15:0] left_axis_x;
    logic signed [15:0] left_axis_y;
    logic signed [14:0] right_axis_x;
    logic signed [14:0] right_axis_y;
    logic [15:0]        left_trigger_level;
    logic [15:0]        right_trigger_level;

    int          fail_count;
    int          pending;
    int          cycles;
    bit          idle_on;
    bit          long_hold;
    logic [31:0] last_sent;

    gamepad_report_conditioner u_top (.*);
    report_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold that backs up the block.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                long_hold = 0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only with the block idle; dropped reports need no result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic send_report(input logic conn, input logic [31:0] pkt,
                               input logic [15:0] btn,
                               input logic [15:0] lx, input logic [15:0] ly,
                               input logic [15:0] rx, input logic [15:0] ry,
                               input logic [7:0] lt, input logic [7:0] rt);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        connected         <= conn;
        packet_number     <= pkt;
        button_bits       <= btn;
        left_stick_x      <= lx;
        left_stick_y      <= ly;
        right_stick_x     <= rx;
        right_stick_y     <= ry;
        left_trigger_raw  <= lt;
        right_trigger_raw <= rt;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        last_sent = pkt;
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 4000)) - 2000);
            3: return 16'(int'($urandom_range(0, 24000)) - 12000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_report();
        logic [31:0] pkt;
        logic        conn;
        conn = ($urandom_range(0, 9) != 0);
        pkt = ($urandom_range(0, 9) == 0) ? last_sent : $urandom;
        send_report(conn, pkt, 16'($urandom), pick_axis(), pick_axis(), pick_axis(),
                    pick_axis(), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        connected = 1'b0;
        packet_number = '0;
        button_bits = '0;
        left_stick_x = '0;
        left_stick_y = '0;
        right_stick_x = '0;
        right_stick_y = '0;
        left_trigger_raw = '0;
        right_trigger_raw = '0;
        idle_on = 0;
        long_hold = 0;
        last_sent = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset dead zones, packet zero after reset is a repeat.
        send_report(1'b1, 32'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                    8'hFF, 8'hFF);
        send_report(1'b0, 32'd5, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0, 16'h0, 8'hFF, 8'hFF);
        send_report(1'b1, 32'd1, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0, 16'h7FFF, 8'hFF, 8'h00);
        send_report(1'b1, 32'd1, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    8'h00, 8'hFF);
        send_report(1'b1, 32'hFFFFFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    8'h00, 8'hFF);
        send_report(1'b1, 32'h2, 16'hA5A5, 16'h0, 16'h0, 16'h0, 16'h0, 8'h80, 8'h01);
        send_report(1'b1, 32'h3, 16'h5A5A, 16'h0, 16'h8000, 16'h7FFF, 16'h0, 8'h01, 8'h80);
        send_report(1'b1, 32'h4, 16'h5A5A, 16'd7849, 16'h0, 16'd8689, 16'h0, 8'h0, 8'h0);
        send_report(1'b1, 32'h5, 16'h0001, 16'd7850, 16'h0, 16'd8690, 16'h0, 8'h0, 8'h0);
        wait_drained();
        write_reg(gprc_pkg::REG_LEFT_DZ, 15'd0);
        write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd0);
        send_report(1'b1, 32'h6, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h7FFF, 8'h0, 8'h0);
        send_report(1'b1, 32'h7, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h8000, 8'h0, 8'h0);
        send_report(1'b1, 32'h8, 16'h0, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
                    8'h0, 8'h0);
        send_report(1'b1, 32'h9, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0);
        wait_drained();
        write_reg(gprc_pkg::REG_LEFT_DZ, 15'd32767);
        write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd32767);
        write_reg(REG_SPARE_LO, 15'd5);
        write_reg(REG_SPARE_HI, 15'd5);
        send_report(1'b1, 32'hA, 16'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h0, 8'h0);
        send_report(1'b1, 32'hB, 16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h0, 8'h0);
        wait_drained();
        write_reg(gprc_pkg::REG_LEFT_DZ, 15'd32766);
        write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd32766);
        send_report(1'b1, 32'hC, 16'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h0, 8'h0);
        send_report(1'b1, 32'hD, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h8000, 8'h0, 8'h0);

        // Random phases, each under a different pair of dead zones.
        idle_on = 1;
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    write_reg(gprc_pkg::REG_LEFT_DZ, gprc_pkg::LEFT_DZ_RST);
                    write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd0);
                end
                1:
                begin
                    write_reg(gprc_pkg::REG_LEFT_DZ, 15'd0);
                    write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd32766);
                end
                2:
                begin
                    write_reg(gprc_pkg::REG_LEFT_DZ, 15'd32767);
                    write_reg(gprc_pkg::REG_RIGHT_DZ, 15'd1);
                end
                default:
                begin
                    write_reg(gprc_pkg::REG_LEFT_DZ, 15'($urandom));
                    write_reg(gprc_pkg::REG_RIGHT_DZ, 15'($urandom_range(0, 20000)));
                end
            endcase
            if (ph == 7)
                idle_on = 0;
            for (int i = 0; i < RANDOM_ITEMS / 8; i++)
            begin
                if (ph == 3 && i == 20)
                    long_hold = 1;
                random_report();
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
